/* sv/kcs_pkg.sv */
// Shared constants, codes and helper functions of the keyframe channel sampler.
package kcs_pkg;

  localparam int MAX_KEYS       = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam int WORDS_PER_KEY  = 12;
  localparam int KEY_W          = $clog2(MAX_KEYS);
  localparam int VAL_DEPTH      = MAX_KEYS * WORDS_PER_KEY;
  localparam int VAL_AW         = $clog2(VAL_DEPTH);

  localparam logic [1:0] OP_WRITE_TIME = 2'd0;
  localparam logic [1:0] OP_WRITE_WORD = 2'd1;
  localparam logic [1:0] OP_SAMPLE     = 2'd2;
  localparam logic [1:0] OP_RESERVED   = 2'd3;

  localparam logic [1:0] LOOP_CLAMP    = 2'd0;
  localparam logic [1:0] LOOP_REPEAT   = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;
  localparam logic [1:0] LOOP_SPARE    = 2'd3;

  localparam logic [1:0] INTERP_STEP   = 2'd0;
  localparam logic [1:0] INTERP_LINEAR = 2'd1;
  localparam logic [1:0] INTERP_CUBIC  = 2'd2;
  localparam logic [1:0] INTERP_SPARE  = 2'd3;

  localparam logic [2:0] CFG_DURATION  = 3'd0;
  localparam logic [2:0] CFG_LOOP      = 3'd1;
  localparam logic [2:0] CFG_INTERP    = 3'd2;
  localparam logic [2:0] CFG_COMPCOUNT = 3'd3;
  localparam logic [2:0] CFG_KEYCOUNT  = 3'd4;

  localparam logic [3:0] SEC_IN_TANGENT  = 4'd0;
  localparam logic [3:0] SEC_VALUE       = 4'd4;
  localparam logic [3:0] SEC_OUT_TANGENT = 4'd8;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    if (x[71:31] == {41{x[71]}}) begin
      return x[31:0];
    end else if (x[71]) begin
      return Q_MIN;
    end
    return Q_MAX;
  endfunction

  function automatic logic [VAL_AW-1:0] word_addr(input logic [KEY_W-1:0] key,
                                                  input logic [3:0] slot);
    logic [VAL_AW-1:0] k;
    k = VAL_AW'(key);
    return (k << 3) + (k << 2) + VAL_AW'(slot);
  endfunction

endpackage

/* sv/kcs_if.sv */
// Stream interfaces for input items and sampled results.
interface kcs_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [5:0]         key_index;
  logic [3:0]         word_slot;
  logic signed [31:0] write_data;
  logic signed [31:0] query_time;

  modport source(output valid, operation, key_index, word_slot, write_data, query_time,
                 input ready);
  modport sink(input valid, operation, key_index, word_slot, write_data, query_time,
               output ready);
endinterface

interface kcs_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         component_index;
  logic signed [31:0] sample_value;
  logic               last;

  modport source(output valid, component_index, sample_value, last, input ready);
  modport sink(input valid, component_index, sample_value, last, output ready);
endinterface

/* sv/keyframe_channel_sampler.sv */
// Keyframe channel sampler: key table, time wrap, key search and interpolation.
// A sample first wraps the time in every loop mode but clamp, when the duration is nonzero (a
// 32-step remainder unit), then searches the keys at one key time per cycle, runs a 16-bit
// fraction division for linear and cubic, then one multiply per component for linear or step, and
// two fraction powers once plus six multiplies per component for cubic, all on the shared bit-serial multiplier.
// Synchronous reset clears the configuration registers, the state and the output valid; the key tables are not cleared.
module keyframe_channel_sampler (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  kcs_item_if.sink            items,
  kcs_result_if.source        results
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_WRAP   = 12'b000000000010,
    ST_WFIX   = 12'b000000000100,
    ST_CMP0   = 12'b000000001000,
    ST_SCAN   = 12'b000000010000,
    ST_FRAC   = 12'b000000100000,
    ST_PREP   = 12'b000001000000,
    ST_LOAD   = 12'b000010000000,
    ST_MSTART = 12'b000100000000,
    ST_MUL    = 12'b001000000000,
    ST_MPOST  = 12'b010000000000,
    ST_EMIT   = 12'b100000000000
  } state_t;

  localparam logic [3:0] MS_T2  = 4'd0;
  localparam logic [3:0] MS_T3  = 4'd1;
  localparam logic [3:0] MS_M0  = 4'd2;
  localparam logic [3:0] MS_M1  = 4'd3;
  localparam logic [3:0] MS_H00 = 4'd4;
  localparam logic [3:0] MS_H10 = 4'd5;
  localparam logic [3:0] MS_H01 = 4'd6;
  localparam logic [3:0] MS_H11 = 4'd7;
  localparam logic [3:0] MS_LIN = 4'd8;

  logic [30:0] clip_duration;
  logic [1:0]  loop_mode;
  logic [1:0]  interp_mode;
  logic [2:0]  component_count;
  logic [6:0]  key_count;

  state_t state;
  logic                     tneg;
  logic signed [31:0]       tw;
  logic [kcs_pkg::KEY_W-1:0] idx;
  logic [kcs_pkg::KEY_W-1:0] ka;
  logic [kcs_pkg::KEY_W-1:0] kb;
  logic signed [31:0]       prev_time;
  logic signed [33:0]       interval;
  logic [15:0]              frac;
  logic [15:0]              t2;
  logic [15:0]              t3;
  logic [1:0]               comp;
  logic [2:0]               rphase;
  logic signed [31:0]       p0;
  logic signed [31:0]       p1;
  logic signed [31:0]       wa;
  logic signed [31:0]       wb;
  logic signed [49:0]       m0;
  logic signed [49:0]       m1;
  logic [3:0]               mstep;
  logic signed [31:0]       result;

  logic signed [85:0] ma;
  logic signed [85:0] acc;
  logic [33:0]        mb;
  logic [5:0]         mcnt;
  logic [5:0]         mbits;

  logic [33:0] dv_rem;
  logic [32:0] dv_div;
  logic [31:0] dv_num;
  logic [15:0] dv_q;
  logic [5:0]  dv_cnt;
  logic [5:0]  dv_last;

  logic               ov;
  logic [1:0]         o_comp;
  logic signed [31:0] o_val;
  logic               o_last;

  logic                           in_beat;
  logic                           tram_we;
  logic                           vram_we;
  logic [kcs_pkg::KEY_W-1:0]      tr_addr;
  logic [31:0]                    tr_data;
  logic [kcs_pkg::VAL_AW-1:0]     vr_addr;
  logic [31:0]                    vr_data;
  logic signed [31:0]             tdata;
  logic [6:0]                     nkeys;
  logic [2:0]                     ncomp;
  logic                           cubic;
  logic                           last_comp;
  logic [32:0]                    dur33;
  logic [32:0]                    mod_m;
  logic [31:0]                    qmag;
  logic [33:0]                    dv_r2;
  logic                           dv_ge;
  logic [33:0]                    dv_rn;
  logic [15:0]                    dv_qn;
  logic [31:0]                    wr_r1;
  logic [31:0]                    wr_r2;
  logic signed [18:0]             t2e;
  logic signed [18:0]             t3e;
  logic signed [18:0]             fe;
  logic signed [18:0]             h00;
  logic signed [18:0]             h10;
  logic signed [18:0]             h01;
  logic signed [18:0]             h11;
  logic signed [32:0]             pdiff;
  logic signed [71:0]             lin_sum;
  logic signed [71:0]             cub_sum;

  assign items.ready = (state == ST_IDLE);
  assign in_beat     = items.valid && items.ready;
  assign tram_we     = in_beat && (items.operation == kcs_pkg::OP_WRITE_TIME);
  assign vram_we     = in_beat && (items.operation == kcs_pkg::OP_WRITE_WORD)
                       && (items.word_slot < 4'(kcs_pkg::WORDS_PER_KEY));

  assign results.valid           = ov;
  assign results.component_index = o_comp;
  assign results.sample_value    = o_val;
  assign results.last            = o_last;

  kcs_ram #(.WIDTH(32), .DEPTH(kcs_pkg::MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (items.key_index),
    .wdata (items.write_data),
    .raddr (tr_addr),
    .rdata (tr_data)
  );

  kcs_ram #(.WIDTH(32), .DEPTH(kcs_pkg::VAL_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (kcs_pkg::word_addr(items.key_index, items.word_slot)),
    .wdata (items.write_data),
    .raddr (vr_addr),
    .rdata (vr_data)
  );

  always_comb begin
    tdata     = $signed(tr_data);
    nkeys     = (key_count > 7'(kcs_pkg::MAX_KEYS)) ? 7'(kcs_pkg::MAX_KEYS) : key_count;
    ncomp     = (component_count == 3'd0) ? 3'd1 :
                (component_count > 3'(kcs_pkg::MAX_COMPONENTS)) ?
                3'(kcs_pkg::MAX_COMPONENTS) : component_count;
    cubic     = (interp_mode == kcs_pkg::INTERP_CUBIC);
    last_comp = ({1'b0, comp} == ncomp - 3'd1);
    dur33     = {2'b00, clip_duration};
    mod_m     = (loop_mode == kcs_pkg::LOOP_REPEAT) ? dur33 : {1'b0, clip_duration, 1'b0};
    qmag      = items.query_time[31] ? 32'(-items.query_time) : items.query_time;

    dv_r2 = {dv_rem[32:0], dv_num[31]};
    dv_ge = (dv_r2 >= {1'b0, dv_div});
    dv_rn = dv_ge ? dv_r2 - {1'b0, dv_div} : dv_r2;
    dv_qn = {dv_q[14:0], dv_ge};

    wr_r1 = (tneg && (dv_rem[31:0] != 32'd0)) ? mod_m[31:0] - dv_rem[31:0] : dv_rem[31:0];
    wr_r2 = ((loop_mode != kcs_pkg::LOOP_REPEAT) && ({1'b0, wr_r1} > dur33)) ?
            mod_m[31:0] - wr_r1 : wr_r1;

    t2e = $signed({3'b000, t2});
    t3e = $signed({3'b000, t3});
    fe  = $signed({3'b000, frac});
    h00 = (t3e <<< 1) - (t2e + (t2e <<< 1)) + 19'sh10000;
    h10 = t3e - (t2e <<< 1) + fe;
    h01 = (t2e + (t2e <<< 1)) - (t3e <<< 1);
    h11 = t3e - t2e;

    pdiff   = 33'(p1) - 33'(p0);
    lin_sum = 72'(p0) + 72'($signed(acc[85:16]));
    cub_sum = 72'($signed(acc[85:16]));

    case (state)
      ST_CMP0: tr_addr = kcs_pkg::KEY_W'(1);
      ST_SCAN: tr_addr = idx + kcs_pkg::KEY_W'(1);
      default: tr_addr = '0;
    endcase

    case (rphase)
      3'd0:    vr_addr = kcs_pkg::word_addr(ka, kcs_pkg::SEC_VALUE + 4'(comp));
      3'd1:    vr_addr = kcs_pkg::word_addr(kb, kcs_pkg::SEC_VALUE + 4'(comp));
      3'd2:    vr_addr = kcs_pkg::word_addr(ka, kcs_pkg::SEC_OUT_TANGENT + 4'(comp));
      default: vr_addr = kcs_pkg::word_addr(kb, kcs_pkg::SEC_IN_TANGENT + 4'(comp));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_duration   <= '0;
      loop_mode       <= kcs_pkg::LOOP_CLAMP;
      interp_mode     <= kcs_pkg::INTERP_LINEAR;
      component_count <= 3'd3;
      key_count       <= '0;
      state           <= ST_IDLE;
      ov              <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kcs_pkg::CFG_DURATION:  clip_duration   <= cfg_data;
          kcs_pkg::CFG_LOOP:      loop_mode       <= cfg_data[1:0];
          kcs_pkg::CFG_INTERP:    interp_mode     <= cfg_data[1:0];
          kcs_pkg::CFG_COMPCOUNT: component_count <= cfg_data[2:0];
          kcs_pkg::CFG_KEYCOUNT:  key_count       <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (ov && results.ready && (state != ST_EMIT)) begin
        ov <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_beat && (items.operation == kcs_pkg::OP_SAMPLE)) begin
            tneg <= items.query_time[31];
            if (clip_duration == 31'd0) begin
              tw    <= '0;
              state <= ST_CMP0;
            end else if (loop_mode == kcs_pkg::LOOP_CLAMP) begin
              if (items.query_time[31]) begin
                tw <= '0;
              end else if (items.query_time > $signed({1'b0, clip_duration})) begin
                tw <= $signed({1'b0, clip_duration});
              end else begin
                tw <= items.query_time;
              end
              state <= ST_CMP0;
            end else begin
              dv_rem  <= '0;
              dv_div  <= mod_m;
              dv_num  <= qmag;
              dv_cnt  <= '0;
              dv_last <= 6'd31;
              state   <= ST_WRAP;
            end
          end
        end
        ST_WRAP, ST_FRAC: begin
          dv_rem <= dv_rn;
          dv_num <= {dv_num[30:0], 1'b0};
          dv_q   <= dv_qn;
          dv_cnt <= dv_cnt + 6'd1;
          if (dv_cnt == dv_last) begin
            if (state == ST_WRAP) begin
              state <= ST_WFIX;
            end else begin
              frac  <= dv_qn;
              state <= ST_PREP;
            end
          end
        end
        ST_WFIX: begin
          tw    <= $signed(wr_r2);
          state <= ST_CMP0;
        end
        ST_CMP0: begin
          if ((nkeys < 7'd2) || (tw <= tdata)) begin
            ka       <= '0;
            kb       <= '0;
            interval <= '0;
            frac     <= '0;
            state    <= ST_PREP;
          end else begin
            prev_time <= tdata;
            idx       <= kcs_pkg::KEY_W'(1);
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tw < tdata) begin
            ka       <= idx - kcs_pkg::KEY_W'(1);
            kb       <= idx;
            interval <= 34'(tdata) - 34'(prev_time);
            if (interp_mode == kcs_pkg::INTERP_STEP) begin
              frac  <= '0;
              state <= ST_PREP;
            end else begin
              dv_rem  <= 34'(34'(tw) - 34'(prev_time));
              dv_div  <= 33'(33'(tdata) - 33'(prev_time));
              dv_num  <= '0;
              dv_cnt  <= '0;
              dv_last <= 6'd15;
              state   <= ST_FRAC;
            end
          end else if ({1'b0, idx} == nkeys - 7'd1) begin
            ka       <= idx;
            kb       <= idx;
            interval <= '0;
            frac     <= '0;
            state    <= ST_PREP;
          end else begin
            prev_time <= tdata;
            idx       <= idx + kcs_pkg::KEY_W'(1);
          end
        end
        ST_PREP: begin
          comp   <= '0;
          rphase <= '0;
          if (cubic) begin
            mstep <= MS_T2;
            state <= ST_MSTART;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rphase <= rphase + 3'd1;
          case (rphase)
            3'd1:    p0 <= $signed(vr_data);
            3'd2:    p1 <= $signed(vr_data);
            3'd3:    wa <= $signed(vr_data);
            3'd4:    wb <= $signed(vr_data);
            default: ;
          endcase
          if (rphase == 3'd4) begin
            mstep <= cubic ? MS_M0 : MS_LIN;
            state <= ST_MSTART;
          end
        end
        ST_MSTART: begin
          mcnt  <= '0;
          mbits <= 6'd18;
          case (mstep)
            MS_T2: begin
              ma <= 86'({1'b0, frac});
              mb <= 34'(frac);
            end
            MS_T3: begin
              ma <= 86'({1'b0, t2});
              mb <= 34'(frac);
            end
            MS_M0: begin
              ma    <= 86'(wa);
              mb    <= interval;
              mbits <= 6'd34;
            end
            MS_M1: begin
              ma    <= 86'(wb);
              mb    <= interval;
              mbits <= 6'd34;
            end
            MS_H00: begin
              ma <= 86'(p0);
              mb <= 34'(h00[17:0]) | {{16{h00[17]}}, 18'd0};
            end
            MS_H10: begin
              ma <= 86'(m0);
              mb <= 34'(h10[17:0]) | {{16{h10[17]}}, 18'd0};
            end
            MS_H01: begin
              ma <= 86'(p1);
              mb <= 34'(h01[17:0]) | {{16{h01[17]}}, 18'd0};
            end
            MS_H11: begin
              ma <= 86'(m1);
              mb <= 34'(h11[17:0]) | {{16{h11[17]}}, 18'd0};
            end
            default: begin
              ma <= 86'(pdiff);
              mb <= 34'(frac);
            end
          endcase
          case (mstep)
            MS_H10, MS_H01, MS_H11: ;
            default: acc <= '0;
          endcase
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mb[0]) begin
            acc <= (mcnt == mbits - 6'd1) ? acc - ma : acc + ma;
          end
          ma   <= ma <<< 1;
          mb   <= {mb[33], mb[33:1]};
          mcnt <= mcnt + 6'd1;
          if (mcnt == mbits - 6'd1) begin
            state <= ST_MPOST;
          end
        end
        ST_MPOST: begin
          state <= ST_MSTART;
          case (mstep)
            MS_T2: begin
              t2    <= acc[31:16];
              mstep <= MS_T3;
            end
            MS_T3: begin
              t3     <= acc[31:16];
              rphase <= '0;
              state  <= ST_LOAD;
            end
            MS_M0: begin
              m0    <= acc[65:16];
              mstep <= MS_M1;
            end
            MS_M1: begin
              m1    <= acc[65:16];
              mstep <= MS_H00;
            end
            MS_H00: mstep <= MS_H10;
            MS_H10: mstep <= MS_H01;
            MS_H01: mstep <= MS_H11;
            MS_H11: begin
              result <= kcs_pkg::sat32(cub_sum);
              state  <= ST_EMIT;
            end
            default: begin
              result <= kcs_pkg::sat32(lin_sum);
              state  <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (!ov || results.ready) begin
            ov     <= 1'b1;
            o_comp <= comp;
            o_val  <= result;
            o_last <= last_comp;
            if (last_comp) begin
              state <= ST_IDLE;
            end else begin
              comp   <= comp + 2'd1;
              rphase <= '0;
              state  <= ST_LOAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/kcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the keyframe channel sampler with a predicting scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int FILL_KEYS = 12;

  typedef struct {
    logic [1:0]         comp;
    logic signed [31:0] value;
    logic               last;
  } sampled_value_t;

  typedef struct {
    logic [30:0] duration;
    logic [1:0]  loop_sel;
    logic [1:0]  interp_sel;
    logic [2:0]  comps;
    logic [6:0]  keys;
  } clip_setup_t;

  class sampler_model;
    logic [31:0]    key_time_tab[kcs_pkg::MAX_KEYS];
    logic [31:0]    key_word_tab[kcs_pkg::VAL_DEPTH];
    logic [30:0]    duration;
    logic [1:0]     loop_sel;
    logic [1:0]     interp_sel;
    logic [2:0]     comps;
    logic [6:0]     keys;
    sampled_value_t pending_values[$];
    int             mismatches;

    function new();
      duration   = 0;
      loop_sel   = kcs_pkg::LOOP_CLAMP;
      interp_sel = kcs_pkg::INTERP_LINEAR;
      comps      = 3'd3;
      keys       = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] data);
      case (idx)
        kcs_pkg::CFG_DURATION:  duration = data;
        kcs_pkg::CFG_LOOP:      loop_sel = data[1:0];
        kcs_pkg::CFG_INTERP:    interp_sel = data[1:0];
        kcs_pkg::CFG_COMPCOUNT: comps = data[2:0];
        kcs_pkg::CFG_KEYCOUNT:  keys = data[6:0];
        default: ;
      endcase
    endfunction

    function longint ktime(int k);
      return longint'($signed(key_time_tab[k]));
    endfunction

    function longint kword(int k, int slot);
      return longint'($signed(key_word_tab[k * kcs_pkg::WORDS_PER_KEY + slot]));
    endfunction

    function longint wrapped(longint t);
      longint d;
      longint c;
      d = longint'(duration);
      if (d == 0) return 0;
      if (loop_sel == kcs_pkg::LOOP_CLAMP) return t < 0 ? 0 : (t > d ? d : t);
      if (loop_sel == kcs_pkg::LOOP_REPEAT) begin
        c = t % d;
        return c < 0 ? c + d : c;
      end
      c = t % (2 * d);
      if (c < 0) c += 2 * d;
      return c > d ? 2 * d - c : c;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void note_item(logic [1:0] op, logic [5:0] ki, logic [3:0] slot,
                            logic [31:0] data, logic [31:0] qt);
      int             n, cnt, ka, kb;
      longint         t, f, span, p0, p1, v, t2, t3, m0, m1;
      sampled_value_t r;
      if (op == kcs_pkg::OP_WRITE_TIME) begin
        key_time_tab[ki] = data;
        return;
      end
      if (op == kcs_pkg::OP_WRITE_WORD) begin
        if (slot < kcs_pkg::WORDS_PER_KEY)
          key_word_tab[ki * kcs_pkg::WORDS_PER_KEY + slot] = data;
        return;
      end
      if (op != kcs_pkg::OP_SAMPLE) return;
      n = keys > kcs_pkg::MAX_KEYS ? kcs_pkg::MAX_KEYS : keys;
      cnt = comps < 1 ? 1 : (comps > kcs_pkg::MAX_COMPONENTS ? kcs_pkg::MAX_COMPONENTS : comps);
      t = wrapped(longint'($signed(qt)));
      ka = 0;
      kb = 0;
      f = 0;
      if (n >= 2 && t > ktime(0)) begin
        ka = n - 1;
        kb = n - 1;
        for (int i = 0; i + 1 < n; i++) begin
          if (t < ktime(i + 1)) begin
            ka = i;
            kb = i + 1;
            f = ((t - ktime(i)) * 65536) / (ktime(i + 1) - ktime(i));
            break;
          end
        end
      end
      if (interp_sel == kcs_pkg::INTERP_STEP) f = 0;
      span = ktime(kb) - ktime(ka);
      for (int i = 0; i < cnt; i++) begin
        p0 = kword(ka, kcs_pkg::SEC_VALUE + i);
        p1 = kword(kb, kcs_pkg::SEC_VALUE + i);
        if (interp_sel == kcs_pkg::INTERP_CUBIC) begin
          t2 = (f * f) >>> 16;
          t3 = (t2 * f) >>> 16;
          m0 = (kword(ka, kcs_pkg::SEC_OUT_TANGENT + i) * span) >>> 16;
          m1 = (kword(kb, kcs_pkg::SEC_IN_TANGENT + i) * span) >>> 16;
          v = ((2 * t3 - 3 * t2 + 65536) * p0 + (t3 - 2 * t2 + f) * m0
               + (-2 * t3 + 3 * t2) * p1 + (t3 - t2) * m1) >>> 16;
        end else begin
          v = p0 + (((p1 - p0) * f) >>> 16);
        end
        r.comp  = i[1:0];
        r.value = clamp32(v);
        r.last  = (i + 1 == cnt);
        pending_values.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] comp, logic [31:0] value, logic last);
      sampled_value_t e;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: comp %0d value %h last %0d",
                                       comp, value, last);
        return;
      end
      e = pending_values.pop_front();
      if (comp !== e.comp || value !== e.value || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected comp %0d value %h last %0d, got comp %0d value %h last %0d",
                   e.comp, e.value, e.last, comp, value, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  int          burst_left;
  int          hold_cycles;
  int          ready_phase;
  int          ready_mode;

  kcs_item_if   items();
  kcs_result_if results();

  sampler_model model;

  keyframe_channel_sampler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(items.sink), .results(results.source)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (items.valid && items.ready)
        model.note_item(items.operation, items.key_index, items.word_slot,
                        items.write_data, items.query_time);
      if (results.valid && results.ready)
        model.check_result(results.component_index, results.sample_value, results.last);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      results.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (ready_phase == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_phase <= $urandom_range(20, 300);
      end else begin
        ready_phase <= ready_phase - 1;
      end
      case (ready_mode)
        0: results.ready <= 1'b1;
        1: results.ready <= ($urandom_range(0, 1) == 1);
        default: results.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic send_item(logic [1:0] op, logic [5:0] ki, logic [3:0] slot,
                           logic [31:0] data, logic [31:0] qt);
    @(negedge clk);
    if (burst_left == 0) begin
      items.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    items.operation  = op;
    items.key_index  = ki;
    items.word_slot  = slot;
    items.write_data = data;
    items.query_time = qt;
    items.valid      = 1'b1;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  task automatic sample_at(logic [31:0] qt);
    send_item(kcs_pkg::OP_SAMPLE, 6'($urandom), 4'($urandom), $urandom, qt);
  endtask

  task automatic drain();
    @(negedge clk);
    items.valid = 1'b0;
    while (model.pending_values.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setup(clip_setup_t s);
    drain();
    write_reg(kcs_pkg::CFG_DURATION, s.duration);
    write_reg(kcs_pkg::CFG_LOOP, 31'(s.loop_sel));
    write_reg(kcs_pkg::CFG_INTERP, 31'(s.interp_sel));
    write_reg(kcs_pkg::CFG_COMPCOUNT, 31'(s.comps));
    write_reg(kcs_pkg::CFG_KEYCOUNT, 31'(s.keys));
  endtask

  function automatic logic [31:0] value_word();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h003FFFFF)) - 32'sh001FFFFF);
    endcase
  endfunction

  function automatic logic [31:0] key_stamp(int k);
    return 32'(k * 32'h8000 + $urandom_range(0, 32'h7FFF));
  endfunction

  task automatic random_item(logic [30:0] dur);
    int          pick;
    int          k;
    logic [31:0] qt;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, kcs_pkg::MAX_KEYS - 1);
    if (pick < 8) begin
      send_item(kcs_pkg::OP_WRITE_TIME, 6'(k), 4'($urandom),
                ($urandom_range(0, 4) == 0) ? $urandom : key_stamp(k), $urandom);
    end else if (pick < 28) begin
      send_item(kcs_pkg::OP_WRITE_WORD, 6'(k), 4'($urandom_range(0, 15)), value_word(),
                $urandom);
    end else if (pick < 32) begin
      send_item(kcs_pkg::OP_RESERVED, 6'($urandom), 4'($urandom), $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 5) == 0) qt = $urandom;
      else qt = 32'($signed($urandom_range(0, 32'h7FFFFFF)) - 32'sh1000000)
                 + ((dur != 0) ? 32'($urandom_range(0, 32'(dur))) : 32'd0);
      sample_at(qt);
    end
  endtask

  clip_setup_t setups[8];
  clip_setup_t s;

  initial begin
    model = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = kcs_pkg::CFG_DURATION;
    cfg_data = '0;
    items.valid = 1'b0;
    items.operation = kcs_pkg::OP_WRITE_TIME;
    items.key_index = '0;
    items.word_slot = '0;
    items.write_data = '0;
    items.query_time = '0;
    results.ready = 1'b0;
    burst_left = 0;
    hold_cycles = 0;
    ready_phase = 0;
    ready_mode = 0;
    setups[0] = '{31'h00080000, kcs_pkg::LOOP_CLAMP, kcs_pkg::INTERP_LINEAR, 3'd3, 7'd8};
    setups[1] = '{31'h7FFFFFFF, kcs_pkg::LOOP_REPEAT, kcs_pkg::INTERP_CUBIC, 3'd4, 7'd12};
    setups[2] = '{31'h00000000, kcs_pkg::LOOP_PINGPONG, kcs_pkg::INTERP_STEP, 3'd1, 7'd1};
    setups[3] = '{31'h00060000, kcs_pkg::LOOP_SPARE, kcs_pkg::INTERP_SPARE, 3'd0, 7'd11};
    setups[4] = '{31'h00050000, kcs_pkg::LOOP_PINGPONG, kcs_pkg::INTERP_CUBIC, 3'd7, 7'd2};
    setups[5] = '{31'h00000001, kcs_pkg::LOOP_REPEAT, kcs_pkg::INTERP_LINEAR, 3'd2, 7'd0};
    setups[6] = '{31'h00100000, kcs_pkg::LOOP_REPEAT, kcs_pkg::INTERP_CUBIC, 3'd4, 7'd10};
    setups[7] = '{31'h00030000, kcs_pkg::LOOP_PINGPONG, kcs_pkg::INTERP_LINEAR, 3'd4, 7'd12};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every key that a sample can reach so no read hits an unwritten entry.
    for (int k = 0; k < FILL_KEYS; k++) begin
      send_item(kcs_pkg::OP_WRITE_TIME, 6'(k), 4'($urandom), key_stamp(k), $urandom);
      for (int w = 0; w < kcs_pkg::WORDS_PER_KEY; w++)
        send_item(kcs_pkg::OP_WRITE_WORD, 6'(k), 4'(w), value_word(), $urandom);
    end

    for (int p = 0; p < 12; p++) begin
      if (p < 8) s = setups[p];
      else s = '{31'($urandom), 2'($urandom), 2'($urandom),
                 3'($urandom_range(1, 4)), 7'($urandom_range(2, FILL_KEYS))};
      apply_setup(s);
      if (p < 4) begin
        sample_at(32'h00000000);
        sample_at(32'hFFFFFFFF);
        sample_at(32'h7FFFFFFF);
        sample_at(32'h80000000);
        sample_at({1'b0, s.duration});
        sample_at({1'b0, s.duration} + 32'd1);
      end
      if (p == 6) hold_cycles = 3000;
      repeat (11) random_item(s.duration);
      if (p == 9) drain();
    end

    drain();
    if (model.mismatches == 0 && model.pending_values.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/kcs_pkg.sv
sv/kcs_if.sv
sv/kcs_ram.sv
sv/keyframe_channel_sampler.sv
tb/testbench.sv
